FILE: src/ape_pkg.sv
// Package for the atom pair energy unit: widths, constants and word types.
// No dependencies; every other file imports it.
package ape_pkg;

  localparam int CoordWidth = 16;
  localparam int DiffWidth  = (CoordWidth + 1 > 31) ? 31 : CoordWidth + 1;
  localparam int SqWidth    = 2 * DiffWidth;
  localparam int DsqWidth   = SqWidth + 2;
  localparam int RadWidth   = 12;
  localparam int RsumWidth  = RadWidth + 1;
  localparam int EpsWidth   = 16;
  localparam int CfWidth    = 16;
  localparam int KWidth     = 16;
  localparam int S2Width    = 2 * RsumWidth + KWidth + 1 - 16;
  localparam int D0Width    = RsumWidth + CfWidth;
  localparam int D0sqWidth  = 2 * D0Width;
  localparam int QuotWidth  = 48;

  localparam logic [KWidth-1:0]  SigmaSqK    = 16'd52059;
  localparam logic [63:0]        ClampMax    = 64'h7FFF_FFFF;
  localparam logic signed [31:0] EMax        = 32'sh7FFF_FFFF;
  localparam logic [CfWidth-1:0] CfReset     = 16'd16384;

  // Register indexes of the configuration port
  localparam logic RegEnergyMode = 1'b0;
  localparam logic RegCollFactor = 1'b1;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_a_x;
    logic signed [CoordWidth-1:0] pos_a_y;
    logic signed [CoordWidth-1:0] pos_a_z;
    logic signed [CoordWidth-1:0] pos_b_x;
    logic signed [CoordWidth-1:0] pos_b_y;
    logic signed [CoordWidth-1:0] pos_b_z;
    logic [RadWidth-1:0]          radius_a;
    logic [RadWidth-1:0]          radius_b;
    logic [EpsWidth-1:0]          pair_epsilon;
  } ape_in_t;

  typedef struct packed {
    logic signed [31:0] pair_energy;
    logic               saturated;
    logic               zero_distance;
  } ape_out_t;

  // Side information that rides along the divider chain
  typedef struct packed {
    logic                mode;
    logic                zero;
    logic                big;
    logic                cond1;
    logic [EpsWidth-1:0] eps;
  } ape_side_t;

  // Word held by one divider cell: two restoring-division lanes
  typedef struct packed {
    logic [DsqWidth-1:0]  rem1;
    logic [DsqWidth-1:0]  div1;
    logic [QuotWidth-1:0] nq1;
    logic [D0sqWidth-1:0] rem2;
    logic [D0sqWidth-1:0] div2;
    logic [QuotWidth-1:0] nq2;
    ape_side_t            side;
  } ape_div_t;

endpackage

FILE: src/ape_div_cell.sv
// One cell of the divider chain: one quotient bit for each of two lanes.
// Depends on ape_pkg.
module ape_div_cell import ape_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  ape_div_t cell_i,
  output logic     valid_o,
  output ape_div_t cell_o
);

  logic [DsqWidth:0]  sh1, df1;
  logic [D0sqWidth:0] sh2, df2;
  logic               fit1, fit2;
  ape_div_t           cell_d, cell_q;
  logic               valid_q;

  always_comb begin
    sh1  = {cell_i.rem1, cell_i.nq1[QuotWidth-1]};
    df1  = sh1 - {1'b0, cell_i.div1};
    fit1 = sh1 >= {1'b0, cell_i.div1};
    sh2  = {cell_i.rem2, cell_i.nq2[QuotWidth-1]};
    df2  = sh2 - {1'b0, cell_i.div2};
    fit2 = sh2 >= {1'b0, cell_i.div2};

    cell_d      = cell_i;
    cell_d.rem1 = fit1 ? df1[DsqWidth-1:0] : sh1[DsqWidth-1:0];
    cell_d.nq1  = {cell_i.nq1[QuotWidth-2:0], fit1};
    cell_d.rem2 = fit2 ? df2[D0sqWidth-1:0] : sh2[D0sqWidth-1:0];
    cell_d.nq2  = {cell_i.nq2[QuotWidth-2:0], fit2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

FILE: src/ape_front.sv
// Front stages: distance squared, sigma squared, collision distance, divider setup.
// Depends on ape_pkg.
module ape_front import ape_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ape_in_t            word_i,
  input  logic               mode_i,
  input  logic [CfWidth-1:0] cf_i,
  output logic               valid_o,
  output ape_div_t           cell_o
);

  function automatic logic [DiffWidth-1:0] axis_mag(
    input logic signed [CoordWidth-1:0] a,
    input logic signed [CoordWidth-1:0] b
  );
    logic signed [CoordWidth:0] d;
    logic [CoordWidth:0]        m;
    d = {a[CoordWidth-1], a} - {b[CoordWidth-1], b};
    m = d[CoordWidth] ? (CoordWidth+1)'(-d) : (CoordWidth+1)'(d);
    return (64'(m) > ClampMax) ? DiffWidth'(ClampMax) : DiffWidth'(m);
  endfunction

  // stage 0: axis magnitudes
  logic                 v0_q;
  logic [DiffWidth-1:0] dx0_q, dy0_q, dz0_q;
  logic [RsumWidth-1:0] rs0_q;
  logic [EpsWidth-1:0]  eps0_q;
  logic                 mode0_q;
  logic [CfWidth-1:0]   cf0_q;
  // stage 1: squares
  logic                   v1_q;
  logic [SqWidth-1:0]     sx1_q, sy1_q, sz1_q;
  logic [2*RsumWidth-1:0] rsq1_q;
  logic [RsumWidth-1:0]   rs1_q;
  logic [EpsWidth-1:0]    eps1_q;
  logic                   mode1_q;
  logic [CfWidth-1:0]     cf1_q;
  // stage 2: distance sum, scaled radius terms
  logic                          v2_q;
  logic [DsqWidth-1:0]           dsq2_q;
  logic [2*RsumWidth+KWidth-1:0] rk2_q;
  logic [D0Width-1:0]            d02_q;
  logic [EpsWidth-1:0]           eps2_q;
  logic                          mode2_q;
  // stage 3: sigma squared, collision distance squared
  logic                 v3_q;
  logic [DsqWidth-1:0]  dsq3_q;
  logic [S2Width-1:0]   s23_q;
  logic [D0sqWidth-1:0] d0sq3_q;
  logic [EpsWidth-1:0]  eps3_q;
  logic                 mode3_q;
  // stage 4: divider entry
  logic     v4_q;
  ape_div_t cell_d, cell_q;

  logic [2*RsumWidth+KWidth:0] rk_rnd;
  logic                        zero, big, cond1, lane2_on;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_comb begin
    rk_rnd   = (2*RsumWidth+KWidth+1)'(rk2_q) + (2*RsumWidth+KWidth+1)'(16'h8000);
    zero     = (dsq3_q == '0);
    big      = !mode3_q && ({25'd0, s23_q} >= {dsq3_q, 16'd0});
    cond1    = mode3_q && !zero && (dsq3_q <= DsqWidth'(d0sq3_q[D0sqWidth-1:28]));
    lane2_on = mode3_q && (d0sq3_q[D0sqWidth-1:28] != '0);

    cell_d.div1 = dsq3_q;
    cell_d.div2 = d0sq3_q;
    cell_d.rem1 = '0;
    cell_d.nq1  = '0;
    if (!zero && !big) begin
      if (mode3_q) begin
        cell_d.nq1 = QuotWidth'(64'h1_0000_0000);
      end else begin
        cell_d.rem1 = DsqWidth'(s23_q[S2Width-1:16]);
        cell_d.nq1  = {s23_q[15:0], 32'd0};
      end
    end
    // 2^60 over the collision distance squared
    cell_d.rem2 = lane2_on ? D0sqWidth'(13'h1000) : '0;
    cell_d.nq2  = '0;

    cell_d.side.mode  = mode3_q;
    cell_d.side.zero  = zero;
    cell_d.side.big   = big;
    cell_d.side.cond1 = cond1;
    cell_d.side.eps   = eps3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx0_q   <= axis_mag(word_i.pos_a_x, word_i.pos_b_x);
      dy0_q   <= axis_mag(word_i.pos_a_y, word_i.pos_b_y);
      dz0_q   <= axis_mag(word_i.pos_a_z, word_i.pos_b_z);
      rs0_q   <= RsumWidth'(word_i.radius_a) + RsumWidth'(word_i.radius_b);
      eps0_q  <= word_i.pair_epsilon;
      mode0_q <= mode_i;
      cf0_q   <= cf_i;

      sx1_q   <= dx0_q * dx0_q;
      sy1_q   <= dy0_q * dy0_q;
      sz1_q   <= dz0_q * dz0_q;
      rsq1_q  <= rs0_q * rs0_q;
      rs1_q   <= rs0_q;
      eps1_q  <= eps0_q;
      mode1_q <= mode0_q;
      cf1_q   <= cf0_q;

      dsq2_q  <= DsqWidth'(sx1_q) + DsqWidth'(sy1_q) + DsqWidth'(sz1_q);
      rk2_q   <= rsq1_q * SigmaSqK;
      d02_q   <= rs1_q * cf1_q;
      eps2_q  <= eps1_q;
      mode2_q <= mode1_q;

      dsq3_q  <= dsq2_q;
      s23_q   <= rk_rnd[2*RsumWidth+KWidth:16];
      d0sq3_q <= d02_q * d02_q;
      eps3_q  <= eps2_q;
      mode3_q <= mode2_q;

      cell_q  <= cell_d;
    end
  end

  assign valid_o = v4_q;
  assign cell_o  = cell_q;

endmodule

FILE: src/ape_back.sv
// Back stages: powers of the ratio, epsilon scaling, saturation and the output register.
// Depends on ape_pkg.
module ape_back import ape_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  ape_div_t cell_i,
  output logic     valid_o,
  output ape_out_t word_o
);

  typedef struct packed {
    logic                mode;
    logic                zero;
    logic                cond1;
    logic                psat;
    logic [EpsWidth-1:0] eps;
    logic [32:0]         m1;
  } bk_side_t;

  logic [7:0] v_q;
  bk_side_t   sd_d, sd1_q, sd2_q, sd3_q, sd4_d, sd4_q, sd5_q, sd6_q, sd7_q;

  logic [47:0] u1_q, u2u_q;
  logic [63:0] a1_q; logic [47:0] b1_q; logic [31:0] c1_q;
  logic [63:0] p2_q;
  logic [63:0] ll3_q, hl3_q; logic [47:0] lh3_q, hh3_q;
  logic [47:0] u34_q;
  logic [63:0] a5_q; logic [47:0] b5_q; logic [31:0] c5_q; logic [47:0] u35_q;
  logic [63:0] diff6_q; logic neg6_q;
  logic [47:0] pl7_q, ph7_q; logic neg7_q;
  ape_out_t    out_d, out_q;

  logic [95:0]  sq2, sq6;
  logic [111:0] pr4;
  logic [79:0]  pr8;
  logic [30:0]  mag;
  logic         ovf;

  always_comb begin
    sd_d.mode  = cell_i.side.mode;
    sd_d.zero  = cell_i.side.zero;
    sd_d.cond1 = cell_i.side.cond1;
    sd_d.psat  = cell_i.side.big;
    sd_d.eps   = cell_i.side.eps;
    sd_d.m1    = cell_i.nq1[32:0] - cell_i.nq2[32:0];

    sq2 = 96'(a1_q) + (96'(b1_q) << 33) + (96'(c1_q) << 64);
    pr4 = 112'(ll3_q) + (112'(lh3_q) << 32) + (112'(hl3_q) << 32) + (112'(hh3_q) << 64);
    sq6 = 96'(a5_q) + (96'(b5_q) << 33) + (96'(c5_q) << 64);
    pr8 = 80'(pl7_q) + (80'(ph7_q) << 32);
    ovf = (pr8[79:57] != '0);
    mag = pr8[56:26];

    sd4_d      = sd3_q;
    sd4_d.psat = sd3_q.psat || (pr4[111:80] != '0);

    out_d.zero_distance = 1'b0;
    out_d.saturated     = 1'b0;
    out_d.pair_energy   = '0;
    if (sd7_q.zero) begin
      out_d.zero_distance = 1'b1;
      out_d.saturated     = 1'b1;
      out_d.pair_energy   = EMax;
    end else if (!sd7_q.mode) begin
      if (sd7_q.eps != '0) begin
        if (sd7_q.psat || ovf) begin
          out_d.saturated   = 1'b1;
          out_d.pair_energy = EMax;
        end else if (neg7_q) begin
          out_d.pair_energy = 32'sd0 - signed'({1'b0, mag});
        end else begin
          out_d.pair_energy = signed'({1'b0, mag});
        end
      end
    end else if (sd7_q.cond1) begin
      if (sd7_q.m1[32:31] != 2'd0) begin
        out_d.saturated   = 1'b1;
        out_d.pair_energy = EMax;
      end else begin
        out_d.pair_energy = signed'({1'b0, sd7_q.m1[30:0]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // square of the ratio
      u1_q  <= cell_i.nq1;
      a1_q  <= cell_i.nq1[31:0] * cell_i.nq1[31:0];
      b1_q  <= cell_i.nq1[31:0] * cell_i.nq1[47:32];
      c1_q  <= cell_i.nq1[47:32] * cell_i.nq1[47:32];
      sd1_q <= sd_d;

      p2_q  <= sq2[95:32];
      u2u_q <= u1_q;
      sd2_q <= sd1_q;

      // cube
      ll3_q <= p2_q[31:0] * u2u_q[31:0];
      lh3_q <= p2_q[31:0] * u2u_q[47:32];
      hl3_q <= p2_q[63:32] * u2u_q[31:0];
      hh3_q <= p2_q[63:32] * u2u_q[47:32];
      sd3_q <= sd2_q;

      u34_q <= pr4[79:32];
      sd4_q <= sd4_d;

      // sixth power
      a5_q  <= u34_q[31:0] * u34_q[31:0];
      b5_q  <= u34_q[31:0] * u34_q[47:32];
      c5_q  <= u34_q[47:32] * u34_q[47:32];
      u35_q <= u34_q;
      sd5_q <= sd4_q;

      if (sq6[95:32] >= 64'(u35_q)) begin
        diff6_q <= sq6[95:32] - 64'(u35_q);
        neg6_q  <= 1'b0;
      end else begin
        diff6_q <= 64'(u35_q) - sq6[95:32];
        neg6_q  <= 1'b1;
      end
      sd6_q <= sd5_q;

      pl7_q  <= sd6_q.eps * diff6_q[31:0];
      ph7_q  <= sd6_q.eps * diff6_q[63:32];
      neg7_q <= neg6_q;
      sd7_q  <= sd6_q;

      out_q <= out_d;
    end
  end

  assign valid_o = v_q[7];
  assign word_o  = out_q;

endmodule

FILE: src/atom_pair_energy_unit.sv
// Top level of the atom pair energy unit: config port, pipeline and divider chain.
// Depends on ape_pkg, ape_front, ape_div_cell and ape_back.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+----------------------------
//   in      | into      | in_valid_i/in_stall_o | ape_in_t: positions, radii, eps
//   out     | out of    | out_valid_o/out_stall_i| ape_out_t: energy, flags
//   cfg     | into      | APB psel/penable      | energy_mode @0, collision_factor @4
//
// One word enters per cycle unless the pipeline stalls. The pipeline holds 5 front
// stages, 48 divider cells (one quotient bit per cell for the ratio and the collision
// terms) and 8 back stages ending in the output register.
// Reset clears all valid bits and sets energy_mode to 0, collision_factor to 16384.
// A stall on the output while a valid word waits there freezes the whole pipeline; the input stalls in that cycle.
module atom_pair_energy_unit import ape_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ape_in_t     in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ape_out_t    out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               mode_q;
  logic [CfWidth-1:0] cf_q;
  logic               en;

  logic     cv [QuotWidth+1];
  ape_div_t cd [QuotWidth+1];

  // Advance everything unless a finished word waits on a stalled output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign pready     = 1'b1;

  // Config registers; decode on address bit 2 only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      cf_q   <= CfReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegEnergyMode: mode_q <= pwdata[0];
        RegCollFactor: cf_q   <= pwdata[CfWidth-1:0];
        default:       mode_q <= mode_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegEnergyMode: prdata = {31'd0, mode_q};
      RegCollFactor: prdata = {16'd0, cf_q};
      default:       prdata = '0;
    endcase
  end

  ape_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .mode_i  (mode_q),
    .cf_i    (cf_q),
    .valid_o (cv[0]),
    .cell_o  (cd[0])
  );

  // Divider chain: each cell hands its word to the next one every cycle unless the pipeline is stalled
  for (genvar i = 0; i < QuotWidth; i++) begin : g_cell
    ape_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[i]),
      .cell_i  (cd[i]),
      .valid_o (cv[i+1]),
      .cell_o  (cd[i+1])
    );
  end

  ape_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv[QuotWidth]),
    .cell_i  (cd[QuotWidth]),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.zero_distance |->
      out_word_o.saturated && (out_word_o.pair_energy == EMax))
    else $error("zero distance word not saturated");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.saturated |-> out_word_o.pair_energy == EMax)
    else $error("saturated word not at the limit");

  a_coll_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q |-> !out_word_o.pair_energy[31])
    else $error("negative collision energy");
`endif

endmodule
